### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SMM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("smm: property violated");

// Condition must never be seen outside reset.
`define SMM_NEVER(label, clk, rst, cond) \
   `SMM_ASSERT(label, clk, rst, !(cond))

`endif

### hw/rtl/smm_pkg.sv
`default_nettype none

package smm_pkg;

   localparam int MAX_DIM_DEF      = 32;
   localparam int ELEMENT_BITS_DEF = 16;

   localparam int IDX_W     = 5;
   localparam int KIND_W    = 2;
   localparam int VALUE_W   = 16;
   localparam int SIZE_W    = 6;
   localparam int PRODUCT_W = 37;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

   localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } smm_state_type;

endpackage

`default_nettype wire

### hw/rtl/smm_ram.sv
`default_nettype none

module smm_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              write_enable,
   input  wire logic [ADDR_W-1:0] write_addr,
   input  wire logic [WIDTH-1:0]  write_data,
   input  wire logic [ADDR_W-1:0] read_addr,
   output logic      [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

### hw/rtl/square_matrix_multiply.sv
`default_nettype none

// Channel   Ports                                   Handshake
// request   req_kind, req_row, req_col, req_value   start high, busy low at clock edge
// result    rsp_result_row, rsp_result_col,         rsp_valid high for one cycle
//           rsp_product
// config    csr_write_enable, csr_write_data        write at edge with enable high
//
// Loads of A or B are written on acceptance; busy stays low.
// A compute reads each matrix memory once per step for n steps, n being the
// effective size, then passes each pair through a multiply and an accumulate stage;
// with an empty sum no step is issued.
// busy stays high through the cycle that shows the result, so the next request is
// taken only once the result has been shown.
// Reset is synchronous and sets the size register to 32; memories are not cleared.
// The result cannot be stalled; it is shown for exactly one cycle.

module square_matrix_multiply #(
   parameter int MAX_DIM      = smm_pkg::MAX_DIM_DEF,
   parameter int ELEMENT_BITS = smm_pkg::ELEMENT_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [smm_pkg::KIND_W-1:0]          req_kind,
   input  wire logic [smm_pkg::IDX_W-1:0]           req_row,
   input  wire logic [smm_pkg::IDX_W-1:0]           req_col,
   input  wire logic signed [smm_pkg::VALUE_W-1:0]  req_value,
   output logic                                     rsp_valid,
   output logic [smm_pkg::IDX_W-1:0]                rsp_result_row,
   output logic [smm_pkg::IDX_W-1:0]                rsp_result_col,
   output logic signed [smm_pkg::PRODUCT_W-1:0]     rsp_product,
   input  wire logic                                csr_write_enable,
   input  wire logic [smm_pkg::SIZE_W-1:0]          csr_write_data
);

   import smm_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(MAX_DIM + 1);
   localparam int PROD_W = 2 * ELEMENT_BITS;

   smm_state_type state_ff, state_in;

   logic [SIZE_W-1:0]    size_ff;
   logic [IDX_W-1:0]     row_ff, row_in;
   logic [IDX_W-1:0]     col_ff, col_in;
   logic [ADDR_W-1:0]    a_addr_ff, a_addr_in;
   logic [ADDR_W-1:0]    b_addr_ff, b_addr_in;
   logic [CNT_W-1:0]     left_ff, left_in;
   logic                 rd_vld_ff;
   logic                 mul_vld_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic [PRODUCT_W-1:0] acc_ff, acc_in;

   logic                 accept;
   logic                 in_store;
   logic                 issue;
   logic                 finished;
   logic [CNT_W-1:0]     size_eff;
   logic [ADDR_W-1:0]    write_addr;
   logic [ADDR_W-1:0]    row_base;
   logic signed [ELEMENT_BITS-1:0] elem;
   logic                 we_a;
   logic                 we_b;
   logic [ELEMENT_BITS-1:0] rd_a;
   logic [ELEMENT_BITS-1:0] rd_b;

   assign accept   = start && !busy;
   assign in_store = (32'(req_row) < MAX_DIM) && (32'(req_col) < MAX_DIM);
   assign size_eff = (32'(size_ff) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(size_ff);
   assign row_base   = ADDR_W'(32'(req_row) * MAX_DIM);
   assign write_addr = row_base + ADDR_W'(req_col);
   assign elem       = ELEMENT_BITS'(req_value);
   assign we_a = accept && in_store && (req_kind == KIND_LOAD_A);
   assign we_b = accept && in_store && (req_kind == KIND_LOAD_B);
   assign finished = (left_ff == '0) && !rd_vld_ff && !mul_vld_ff;

   smm_ram #(
      .WIDTH  (ELEMENT_BITS),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram_a (
      .clock        (clock),
      .write_enable (we_a),
      .write_addr   (write_addr),
      .write_data   (elem),
      .read_addr    (a_addr_ff),
      .read_data    (rd_a)
   );

   smm_ram #(
      .WIDTH  (ELEMENT_BITS),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram_b (
      .clock        (clock),
      .write_enable (we_b),
      .write_addr   (write_addr),
      .write_data   (elem),
      .read_addr    (b_addr_ff),
      .read_data    (rd_b)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_COMPUTE) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (finished) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      issue     = 1'b0;
      unique case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_RUN:  issue = (left_ff != '0);
         ST_DONE: rsp_valid = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      left_in   = left_ff;
      acc_in    = acc_ff;
      if (accept && req_kind == KIND_COMPUTE) begin
         row_in    = req_row;
         col_in    = req_col;
         a_addr_in = row_base;
         b_addr_in = ADDR_W'(req_col);
         left_in   = in_store ? size_eff : '0;
         acc_in    = '0;
      end else begin
         if (issue) begin
            a_addr_in = a_addr_ff + ADDR_W'(1);
            b_addr_in = b_addr_ff + ADDR_W'(MAX_DIM);
            left_in   = left_ff - CNT_W'(1);
         end
         if (mul_vld_ff) begin
            acc_in = acc_ff + PRODUCT_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         size_ff    <= SIZE_RESET;
         left_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         left_ff    <= left_in;
         rd_vld_ff  <= issue;
         mul_vld_ff <= rd_vld_ff;
         if (csr_write_enable) begin
            size_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      col_ff    <= col_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
      acc_ff    <= acc_in;
      prod_ff   <= $signed(rd_a) * $signed(rd_b);
   end

   assign rsp_result_row = row_ff;
   assign rsp_result_col = col_ff;
   assign rsp_product    = acc_ff;

endmodule

`default_nettype wire

### hw/rtl/smm_checker.sv
`default_nettype none

`include "assert_macros.svh"

module smm_assertions (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire logic [smm_pkg::KIND_W-1:0] req_kind,
   input wire logic                       rsp_valid
);

   import smm_pkg::*;

   logic accept;
   assign accept = start && !busy;

   `SMM_ASSERT(a_compute_busy, clock, reset, (accept && req_kind == KIND_COMPUTE) |=> busy)
   `SMM_ASSERT(a_load_quiet, clock, reset,
      (accept && req_kind != KIND_COMPUTE) |=> (!busy && !rsp_valid))
   `SMM_NEVER(a_result_while_idle, clock, reset, rsp_valid && !busy)
   `SMM_ASSERT(a_result_once, clock, reset, rsp_valid |=> (!busy && !rsp_valid))

endmodule

bind square_matrix_multiply smm_assertions u_smm_checker (.*);

`default_nettype wire

### sim/smm_checker.sv
module smm_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire logic [smm_pkg::KIND_W-1:0]          req_kind,
   input  wire logic [smm_pkg::IDX_W-1:0]           req_row,
   input  wire logic [smm_pkg::IDX_W-1:0]           req_col,
   input  wire logic signed [smm_pkg::VALUE_W-1:0]  req_value,
   input  wire logic                                rsp_valid,
   input  wire logic [smm_pkg::IDX_W-1:0]           rsp_result_row,
   input  wire logic [smm_pkg::IDX_W-1:0]           rsp_result_col,
   input  wire logic signed [smm_pkg::PRODUCT_W-1:0] rsp_product,
   input  wire logic                                csr_write_enable,
   input  wire logic [smm_pkg::SIZE_W-1:0]          csr_write_data,
   output int                                       error_count,
   output int                                       pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import smm_pkg::*;

   localparam int DIM    = MAX_DIM_DEF;
   localparam int CELLS  = DIM * DIM;
   localparam int CELL_W = $clog2(CELLS);

   typedef struct {
      logic [IDX_W-1:0]            row;
      logic [IDX_W-1:0]            col;
      logic signed [PRODUCT_W-1:0] product;
   } product_entry_type;

   product_entry_type         expected_products[$];
   logic signed [VALUE_W-1:0] a_cells [0:CELLS-1];
   logic signed [VALUE_W-1:0] b_cells [0:CELLS-1];
   logic [SIZE_W-1:0]         size_setting = SIZE_RESET;

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   function automatic logic [CELL_W-1:0] cell_at(
      input logic [IDX_W-1:0] r,
      input logic [IDX_W-1:0] c
   );
      return CELL_W'(r) * CELL_W'(DIM) + CELL_W'(c);
   endfunction

   function automatic logic signed [PRODUCT_W-1:0] dot_product(
      input logic [IDX_W-1:0] row,
      input logic [IDX_W-1:0] col
   );
      int                          n;
      logic signed [PRODUCT_W-1:0] acc;
      n   = (size_setting > DIM) ? DIM : int'(size_setting);
      acc = '0;
      for (int k = 0; k < n; k++) begin
         acc = acc + a_cells[cell_at(row, IDX_W'(k))] * b_cells[cell_at(IDX_W'(k), col)];
      end
      return acc;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      product_entry_type want;
      if (reset) begin
         size_setting = SIZE_RESET;
         expected_products.delete();
      end else begin
         if (csr_write_enable) begin
            size_setting = csr_write_data;
         end
         if (rsp_valid) begin
            if (expected_products.size() == 0) begin
               report_mismatch($sformatf("unexpected result row %0d col %0d product %0d",
                                         rsp_result_row, rsp_result_col, rsp_product));
            end else begin
               want = expected_products.pop_front();
               if (rsp_result_row !== want.row) begin
                  report_mismatch($sformatf("result_row %0d, expected %0d",
                                            rsp_result_row, want.row));
               end
               if (rsp_result_col !== want.col) begin
                  report_mismatch($sformatf("result_col %0d, expected %0d",
                                            rsp_result_col, want.col));
               end
               if (rsp_product !== want.product) begin
                  report_mismatch($sformatf("product %0d, expected %0d at row %0d col %0d",
                                            rsp_product, want.product, want.row, want.col));
               end
            end
         end
         if (start && !busy) begin
            case (req_kind)
               KIND_LOAD_A: begin
                  a_cells[cell_at(req_row, req_col)] = req_value;
               end
               KIND_LOAD_B: begin
                  b_cells[cell_at(req_row, req_col)] = req_value;
               end
               KIND_COMPUTE: begin
                  want.row     = req_row;
                  want.col     = req_col;
                  want.product = dot_product(req_row, req_col);
                  expected_products.push_back(want);
               end
               default: begin
               end
            endcase
         end
      end
      pending_count = expected_products.size();
   end

endmodule

### sim/tb_square_matrix_multiply.sv
module tb_square_matrix_multiply;
   timeunit 1ns;
   timeprecision 1ps;

   import smm_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int DIM         = MAX_DIM_DEF;
   localparam int CELL_W      = $clog2(DIM * DIM);
   localparam int CYCLE_LIMIT = 500_000;

   logic                        clock            = 1'b0;
   logic                        reset            = 1'b1;
   logic                        start            = 1'b0;
   logic                        busy;
   logic [KIND_W-1:0]           req_kind         = KIND_UNUSED;
   logic [IDX_W-1:0]            req_row          = '0;
   logic [IDX_W-1:0]            req_col          = '0;
   logic signed [VALUE_W-1:0]   req_value        = '0;
   logic                        rsp_valid;
   logic [IDX_W-1:0]            rsp_result_row;
   logic [IDX_W-1:0]            rsp_result_col;
   logic signed [PRODUCT_W-1:0] rsp_product;
   logic                        csr_write_enable = 1'b0;
   logic [SIZE_W-1:0]           csr_write_data   = '0;

   int error_count;
   int pending_count;
   int cycle_count = 0;
   int items_sent  = 0;
   int eff_size    = DIM;
   bit quiet       = 1'b0;
   bit loaded_a [0:DIM*DIM-1];
   bit loaded_b [0:DIM*DIM-1];

   square_matrix_multiply i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_result_row   (rsp_result_row),
      .rsp_result_col   (rsp_result_col),
      .rsp_product      (rsp_product),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   smm_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_result_row   (rsp_result_row),
      .rsp_result_col   (rsp_result_col),
      .rsp_product      (rsp_product),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("square_matrix_multiply regression: fail");
         $finish;
      end
   end

   function automatic logic [CELL_W-1:0] cell_at(
      input logic [IDX_W-1:0] r,
      input logic [IDX_W-1:0] c
   );
      return CELL_W'(r) * CELL_W'(DIM) + CELL_W'(c);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(0, 9))
         0:       v = 16'sh8000;
         1:       v = 16'sh7fff;
         2:       v = '0;
         default: v = VALUE_W'($urandom);
      endcase
      return v;
   endfunction

   task automatic send_request(
      input logic [KIND_W-1:0]         kind,
      input logic [IDX_W-1:0]          row,
      input logic [IDX_W-1:0]          col,
      input logic signed [VALUE_W-1:0] value
   );
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 9) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start     <= 1'b1;
      req_kind  <= kind;
      req_row   <= row;
      req_col   <= col;
      req_value <= value;
      while (busy) @(negedge clock);
      @(posedge clock);
      if (kind == KIND_LOAD_A) loaded_a[cell_at(row, col)] = 1'b1;
      if (kind == KIND_LOAD_B) loaded_b[cell_at(row, col)] = 1'b1;
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   task automatic idle_until_drained(input int settle);
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] size);
      idle_until_drained(4);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= size;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      eff_size = (size > DIM) ? DIM : int'(size);
   endtask

   // load whatever operands of this product element are still unwritten, then request it
   task automatic compute_at(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
      for (int k = 0; k < eff_size; k++) begin
         if (!loaded_a[cell_at(row, IDX_W'(k))]) begin
            send_request(KIND_LOAD_A, row, IDX_W'(k), pick_value());
         end
         if (!loaded_b[cell_at(IDX_W'(k), col)]) begin
            send_request(KIND_LOAD_B, IDX_W'(k), col, pick_value());
         end
      end
      send_request(KIND_COMPUTE, row, col, VALUE_W'($urandom));
   endtask

   task automatic random_phase(input int items_wanted, input bit hold_midway);
      int               stop_at;
      int               pick;
      int               bound;
      logic [IDX_W-1:0] r;
      logic [IDX_W-1:0] c;
      stop_at = items_sent + items_wanted;
      r = IDX_W'($urandom);
      c = IDX_W'($urandom);
      for (int k = 0; k < eff_size; k++) begin
         send_request(KIND_LOAD_A, r, IDX_W'(k), 16'sh8000);
         send_request(KIND_LOAD_B, IDX_W'(k), c, 16'sh8000);
      end
      compute_at(r, c);
      for (int k = 0; k < eff_size; k++) begin
         send_request(KIND_LOAD_B, IDX_W'(k), c, 16'sh7fff);
      end
      compute_at(r, c);
      while (items_sent < stop_at) begin
         if (hold_midway && items_sent >= stop_at - items_wanted / 2) begin
            idle_until_drained(0);
            hold_midway = 1'b0;
         end
         pick  = $urandom_range(0, 99);
         bound = (eff_size == 0) ? DIM : eff_size;
         if (pick < 8) begin
            send_request(KIND_UNUSED, IDX_W'($urandom), IDX_W'($urandom),
                         VALUE_W'($urandom));
         end else if (pick < 50) begin
            if ($urandom_range(0, 1)) begin
               r = IDX_W'($urandom);
               c = $urandom_range(0, 2) ? IDX_W'($urandom_range(0, bound - 1)) : IDX_W'($urandom);
               send_request(KIND_LOAD_A, r, c, pick_value());
            end else begin
               r = $urandom_range(0, 2) ? IDX_W'($urandom_range(0, bound - 1)) : IDX_W'($urandom);
               c = IDX_W'($urandom);
               send_request(KIND_LOAD_B, r, c, pick_value());
            end
         end else begin
            r = IDX_W'($urandom);
            c = IDX_W'($urandom);
            compute_at(r, c);
         end
      end
   endtask

   initial begin
      logic [SIZE_W-1:0] phase_sizes [0:8];
      phase_sizes = '{6'd32, 6'd1, 6'd63, 6'd2, 6'd0, 6'd5, 6'd33, 6'd17, 6'd1};
      phase_sizes[8] = SIZE_W'($urandom_range(1, DIM));
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(KIND_UNUSED, 5'd31, 5'd31, -16'sd1);
      write_size(6'd1);
      send_request(KIND_LOAD_A, 5'd0, 5'd0, 16'sh8000);
      send_request(KIND_LOAD_B, 5'd0, 5'd0, 16'sh8000);
      send_request(KIND_COMPUTE, 5'd0, 5'd0, 16'sh0000);
      send_request(KIND_LOAD_A, 5'd31, 5'd0, 16'sh7fff);
      send_request(KIND_LOAD_B, 5'd0, 5'd31, 16'sh7fff);
      send_request(KIND_COMPUTE, 5'd31, 5'd31, 16'shffff);
      send_request(KIND_COMPUTE, 5'd31, 5'd0, 16'sh7fff);
      send_request(KIND_COMPUTE, 5'd0, 5'd31, 16'sh8000);
      send_request(KIND_LOAD_A, 5'd0, 5'd0, -16'sd1);
      send_request(KIND_LOAD_B, 5'd0, 5'd0, 16'sd1);
      send_request(KIND_COMPUTE, 5'd0, 5'd0, 16'sh0000);
      send_request(KIND_UNUSED, 5'd0, 5'd0, 16'sh1234);
      send_request(KIND_COMPUTE, 5'd0, 5'd0, 16'sh0000);
      send_request(KIND_LOAD_A, 5'd31, 5'd31, 16'sh0000);
      send_request(KIND_LOAD_B, 5'd31, 5'd31, 16'sh5555);
      write_size(6'd0);
      send_request(KIND_COMPUTE, 5'd17, 5'd9, 16'sh7fff);
      send_request(KIND_COMPUTE, 5'd31, 5'd31, 16'sh8000);

      for (int p = 0; p < 9; p++) begin
         write_size(phase_sizes[p]);
         quiet = (p == 3);
         random_phase(50, p == 1);
      end
      quiet = 1'b0;

      idle_until_drained(40);
      if (error_count == 0) begin
         $display("square_matrix_multiply regression: pass");
      end else begin
         $display("square_matrix_multiply regression: fail");
      end
      $finish;
   end

endmodule
